/* src/wavp_pkg.sv */
// Package for the WAV PCM stream parser: request and result types,
// result and error codes, RIFF tags and fixed header layout constants.
// No dependencies.
package wavp_pkg;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } t_result_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RIFF_WAVE = 3'd1,
        ERR_FMT       = 3'd2,
        ERR_NOT_PCM   = 3'd3,
        ERR_NO_DATA   = 3'd4,
        ERR_FORMAT    = 3'd5
    } t_error_code;

    localparam int unsigned SAMPLE_W = 12;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_file;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        t_result_kind        result_kind;
        logic [SAMPLE_W-1:0] sample_value;
        logic                last_sample;
        t_error_code         error_code;
        logic                rate_ok;
    } t_out_item;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] RATE_RESET   = 32'd32000;
    localparam logic [31:0] FMT_BASE_LEN = 32'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] MONO         = 16'd1;
    localparam logic [15:0] BITS_16      = 16'd16;

    localparam logic [5:0] POS_RIFF_END  = 6'd3;
    localparam logic [5:0] POS_WAVE_END  = 6'd11;
    localparam logic [5:0] POS_FMT_END   = 6'd15;
    localparam logic [5:0] POS_LEN_FIRST = 6'd16;
    localparam logic [5:0] POS_CODE_FIRST = 6'd20;
    localparam logic [5:0] POS_CODE_LAST = 6'd21;
    localparam logic [5:0] POS_CHAN_FIRST = 6'd22;
    localparam logic [5:0] POS_RATE_FIRST = 6'd24;
    localparam logic [5:0] POS_RATE_END  = 6'd28;
    localparam logic [5:0] POS_BITS_FIRST = 6'd34;
    localparam logic [5:0] POS_HDR_LAST  = 6'd35;

    localparam logic [2:0] CHK_TAG_END = 3'd4;
    localparam logic [2:0] CHK_LEN_FIRST = 3'd4;
    localparam logic [2:0] CHK_LAST    = 3'd7;

endpackage

/* src/wav_pcm_stream_parser.sv */
// WAV PCM stream parser top level: header checks, chunk skip and sample
// packing in one registered pass, with an output register and skid stage.
// Depends on wavp_pkg.
//
//   channel   direction  handshake                  payload
//   cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_data (required rate)
//   in        in         i_in_valid / o_in_stall    i_in  (t_in_item)
//   out       out        o_out_valid / i_out_stall  o_out (t_out_item)
//
// One byte request per cycle while the skid stage is empty; any result it
// yields is registered on acceptance, set by the combinational parse state
// update. Synchronous active-low reset clears parse state; the first request
// after reset is taken once reset is released. A stalled result moves to the
// skid stage, and input stalls only while the skid stage is full.
module wav_pcm_stream_parser
    import wavp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_CHUNK  = 3'd2,
        PH_DATA   = 3'd3,
        PH_IDLE   = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase, c_phase;
    logic [5:0]  r_pos, n_pos, c_pos;
    logic [31:0] r_tag, n_tag, c_tag;
    logic [31:0] r_len, n_len, c_len;
    logic [15:0] r_fmt, n_fmt, c_fmt;
    logic [15:0] r_chan, n_chan, c_chan;
    logic [31:0] r_rate, n_rate, c_rate;
    logic [15:0] r_bits, n_bits, c_bits;
    logic [31:0] r_left, n_left, c_left;
    logic        r_hold, n_hold, c_hold;
    logic [7:0]  r_hold_byte, n_hold_byte, c_hold_byte;
    logic [31:0] r_req_rate;

    t_out_item   r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid, res_valid;

    logic        accept, out_take;
    logic [7:0]  b;
    logic        eof;
    logic [31:0] tag_shift, len_dec, left_dec;
    logic [2:0]  cpos;
    logic [SAMPLE_W-1:0] word;

    assign accept      = i_in_valid && !r_skid_valid;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
    assign b           = i_in.data_byte;
    assign eof         = i_in.end_of_file;

    always_comb begin
        c_phase     = r_phase;
        c_pos       = r_pos;
        c_tag       = r_tag;
        c_len       = r_len;
        c_fmt       = r_fmt;
        c_chan      = r_chan;
        c_rate      = r_rate;
        c_bits      = r_bits;
        c_left      = r_left;
        c_hold      = r_hold;
        c_hold_byte = r_hold_byte;
        if (i_in.start_of_file) begin
            c_phase     = PH_HEADER;
            c_pos       = '0;
            c_tag       = '0;
            c_len       = '0;
            c_fmt       = '0;
            c_chan      = '0;
            c_rate      = '0;
            c_bits      = '0;
            c_left      = '0;
            c_hold      = 1'b0;
            c_hold_byte = '0;
        end

        n_phase     = c_phase;
        n_pos       = c_pos;
        n_tag       = c_tag;
        n_len       = c_len;
        n_fmt       = c_fmt;
        n_chan      = c_chan;
        n_rate      = c_rate;
        n_bits      = c_bits;
        n_left      = c_left;
        n_hold      = c_hold;
        n_hold_byte = c_hold_byte;

        res_valid        = 1'b0;
        res              = '0;
        res.result_kind  = KIND_SAMPLE;
        res.error_code   = ERR_NONE;

        tag_shift = {c_tag[23:0], b};
        len_dec   = (c_len != '0) ? c_len - 32'd1 : c_len;
        left_dec  = c_left - 32'd1;
        cpos      = c_pos[2:0];
        word      = {b[3:0], c_hold_byte};

        unique case (c_phase)
            PH_HEADER: begin
                if (c_pos < POS_LEN_FIRST) begin
                    n_tag = tag_shift;
                end
                if (c_pos >= POS_LEN_FIRST && c_pos < POS_CODE_FIRST) begin
                    n_len = c_len | ({24'd0, b} << {c_pos[1:0], 3'b000});
                end else if (c_pos >= POS_CODE_FIRST && c_pos < POS_CHAN_FIRST) begin
                    n_fmt = c_fmt | ({8'd0, b} << {c_pos[0], 3'b000});
                end else if (c_pos >= POS_CHAN_FIRST && c_pos < POS_RATE_FIRST) begin
                    n_chan = c_chan | ({8'd0, b} << {c_pos[0], 3'b000});
                end else if (c_pos >= POS_RATE_FIRST && c_pos < POS_RATE_END) begin
                    n_rate = c_rate | ({24'd0, b} << {c_pos[1:0], 3'b000});
                end else if (c_pos >= POS_BITS_FIRST && c_pos <= POS_HDR_LAST) begin
                    n_bits = c_bits | ({8'd0, b} << {c_pos[0], 3'b000});
                end

                priority if (c_pos == POS_RIFF_END && n_tag != TAG_RIFF) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_RIFF_WAVE;
                end else if (c_pos == POS_WAVE_END && n_tag != TAG_WAVE) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_RIFF_WAVE;
                end else if (c_pos == POS_FMT_END && n_tag != TAG_FMT) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_FMT;
                end else if (c_pos == POS_CODE_LAST && n_fmt != FMT_PCM) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_NOT_PCM;
                end else if (eof) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_NO_DATA;
                end else if (c_pos == POS_HDR_LAST) begin
                    if (c_len > FMT_BASE_LEN) begin
                        n_len   = c_len - FMT_BASE_LEN;
                        n_phase = PH_SKIP;
                    end else begin
                        n_len   = '0;
                        n_phase = PH_CHUNK;
                        n_pos   = '0;
                        n_tag   = '0;
                    end
                end else begin
                    n_pos = c_pos + 6'd1;
                end
            end
            PH_SKIP: begin
                if (eof) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_NO_DATA;
                end else begin
                    n_len = len_dec;
                    if (len_dec == '0) begin
                        n_phase = PH_CHUNK;
                        n_pos   = '0;
                        n_tag   = '0;
                    end
                end
            end
            PH_CHUNK: begin
                if (cpos < CHK_TAG_END) begin
                    n_tag = tag_shift;
                end else begin
                    n_len = ((cpos == CHK_LEN_FIRST) ? 32'd0 : c_len)
                          | ({24'd0, b} << {cpos[1:0], 3'b000});
                end
                if (cpos != CHK_LAST) begin
                    if (eof) begin
                        n_phase = PH_IDLE;
                        res_valid = 1'b1;
                        res.result_kind = KIND_ERROR;
                        res.error_code = ERR_NO_DATA;
                    end else begin
                        n_pos = {3'd0, cpos} + 6'd1;
                    end
                end else if (n_tag == TAG_DATA) begin
                    res_valid = 1'b1;
                    if (c_chan != MONO || c_bits != BITS_16) begin
                        n_phase = PH_IDLE;
                        res.result_kind = KIND_ERROR;
                        res.error_code = ERR_FORMAT;
                    end else begin
                        n_left  = n_len;
                        n_hold  = 1'b0;
                        n_hold_byte = '0;
                        n_phase = (eof || n_len == '0) ? PH_IDLE : PH_DATA;
                        res.result_kind = KIND_HEADER;
                        res.rate_ok = (c_rate == r_req_rate);
                    end
                end else if (eof) begin
                    n_phase = PH_IDLE;
                    res_valid = 1'b1;
                    res.result_kind = KIND_ERROR;
                    res.error_code = ERR_NO_DATA;
                end else if (n_len == '0) begin
                    n_phase = PH_CHUNK;
                    n_pos   = '0;
                    n_tag   = '0;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_DATA: begin
                if (c_left == '0) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_left = left_dec;
                    if (!c_hold) begin
                        if (left_dec == '0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_hold      = 1'b1;
                            n_hold_byte = b;
                        end
                    end else begin
                        n_hold      = 1'b0;
                        n_hold_byte = '0;
                        res_valid   = 1'b1;
                        res.result_kind  = KIND_SAMPLE;
                        res.sample_value = word;
                        res.last_sample  = (left_dec < 32'd2);
                        if (left_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    if (eof) begin
                        n_hold      = 1'b0;
                        n_hold_byte = '0;
                        n_phase     = PH_IDLE;
                    end
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pos        <= '0;
            r_tag        <= '0;
            r_len        <= '0;
            r_fmt        <= '0;
            r_chan       <= '0;
            r_rate       <= '0;
            r_bits       <= '0;
            r_left       <= '0;
            r_hold       <= 1'b0;
            r_hold_byte  <= '0;
            r_req_rate   <= RATE_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_req_rate <= i_cfg_data;
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_pos       <= n_pos;
                r_tag       <= n_tag;
                r_len       <= n_len;
                r_fmt       <= n_fmt;
                r_chan      <= n_chan;
                r_rate      <= n_rate;
                r_bits      <= n_bits;
                r_left      <= n_left;
                r_hold      <= n_hold;
                r_hold_byte <= n_hold_byte;
            end
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept && res_valid) begin
                if (r_out_valid && i_out_stall) begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
